[hw/rtl/bpfa_pkg.sv]
// ----------------------------------------------------------------------------
// Page frame allocator package
// Shared widths, reset values, register indexes, sequencer states and the
// word scan result that passes between the core and its scan unit.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int unsigned NUM_PAGES_DEF = 1048576;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned BIT_W         = 5;
    localparam int unsigned CFG_W         = 21;
    localparam int unsigned PAGE_W        = 20;
    localparam int unsigned PADDR_W       = 4;
    localparam int unsigned PDATA_W       = 32;

    localparam logic [CFG_W-1:0] KERNEL_FIRST_RST = 21'd40;
    localparam logic [CFG_W-1:0] KERNEL_END_RST   = 21'd1024;
    localparam logic [CFG_W-1:0] USER_FIRST_RST   = 21'd1024;
    localparam logic [CFG_W-1:0] USER_END_RST     = 21'd1048576;

    localparam logic [1:0] REG_KERNEL_FIRST = 2'd0;
    localparam logic [1:0] REG_KERNEL_END   = 2'd1;
    localparam logic [1:0] REG_USER_FIRST   = 2'd2;
    localparam logic [1:0] REG_USER_END     = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_ALLOC_WR,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic             hit;
        logic             past_end;
        logic [CFG_W-1:0] page;
        logic [CFG_W-1:0] next_page;
    } t_scan_res;

    // Index of the lowest set bit; zero when none is set
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] vec);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[hw/rtl/bpfa_word_scan.sv]
// ----------------------------------------------------------------------------
// Bitmap word scan unit
// Looks for the lowest free page in one bitmap word at or above the current
// search page and checks it against the end of the search range.
// ----------------------------------------------------------------------------
module bpfa_word_scan (
    input  logic [bpfa_pkg::WORD_W-1:0] i_word,
    input  logic [bpfa_pkg::CFG_W-1:0]  i_page,
    input  logic [bpfa_pkg::CFG_W-1:0]  i_end,
    output bpfa_pkg::t_scan_res         o_res
);

    logic [bpfa_pkg::WORD_W-1:0] free_bits;
    logic                        any_free;
    logic [bpfa_pkg::BIT_W-1:0]  idx;
    logic [bpfa_pkg::CFG_W-1:0]  cand;
    logic [bpfa_pkg::CFG_W-bpfa_pkg::BIT_W-1:0] word_num;

    assign word_num = i_page[bpfa_pkg::CFG_W-1:bpfa_pkg::BIT_W];

    // Treat bits below the search start as used
    assign free_bits = ~i_word & ({bpfa_pkg::WORD_W{1'b1}} << i_page[bpfa_pkg::BIT_W-1:0]);
    assign any_free  = |free_bits;
    assign idx       = bpfa_pkg::lowest_set(free_bits);
    assign cand      = {word_num, idx};

    always_comb begin
        o_res.page      = cand;
        o_res.hit       = any_free && (cand < i_end);
        o_res.past_end  = any_free && !(cand < i_end);
        o_res.next_page = {word_num + 1'b1, {bpfa_pkg::BIT_W{1'b0}}};
    end

endmodule

[hw/rtl/bitmap_page_frame_allocator_core.sv]
// ----------------------------------------------------------------------------
// Bitmap page frame allocator core
// Used/free bitmap with one bit per page, scanned one 32-bit word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis: tuser[0] is the command (0 alloc, 1 free),
//   tuser[1] the zone for alloc (0 kernel, 1 user), tdata[19:0] the page to
//   free. Each request yields one response on m_axis: tdata[19:0] the
//   allocated page (0 on free or out of memory), tuser[0] the status
//   (1 out of memory).
//   Zone ranges [first, end) sit in four APB registers at 0x0, 0x4, 0x8, 0xC.
//   A free reads its bitmap word and writes it back; an allocate reads and
//   scans word by word on the one RAM port and the shared scan unit, then
//   writes back the word of the found page (no write when the lowest free
//   bit seen lies past the range end). One request in flight at a time.
//   After reset the bitmap is set to all used, one word a cycle, over
//   all ceil(NUM_PAGES/32) words (32768 at the default size); s_axis_tready
//   stays low meanwhile. APB writes are taken at any time.
//   A stalled response waits in the output register; the next request is
//   still accepted and its result holds in the core until the output frees.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_core #(
    parameter int unsigned NUM_PAGES = bpfa_pkg::NUM_PAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpfa_pkg::PADDR_W-1:0]  paddr,
    input  logic [bpfa_pkg::PDATA_W-1:0]  pwdata,
    output logic [bpfa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // [19:0] page_in
    input  logic [1:0]                    s_axis_tuser,  // [0] cmd, [1] zone_user
    // response stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,  // [19:0] page_out
    output logic                          m_axis_tuser   // [0] status
);

    localparam int unsigned NUM_WORDS = (NUM_PAGES + bpfa_pkg::WORD_W - 1) / bpfa_pkg::WORD_W;
    localparam int unsigned WA_W      = $clog2(NUM_WORDS);
    localparam logic [bpfa_pkg::CFG_W-1:0] PAGES_LIM = bpfa_pkg::CFG_W'(NUM_PAGES);
    localparam logic [WA_W-1:0]            LAST_WORD = WA_W'(NUM_WORDS - 1);

    // configuration registers
    logic [bpfa_pkg::CFG_W-1:0] r_kernel_first;
    logic [bpfa_pkg::CFG_W-1:0] r_kernel_end;
    logic [bpfa_pkg::CFG_W-1:0] r_user_first;
    logic [bpfa_pkg::CFG_W-1:0] r_user_end;

    // sequencer and datapath
    bpfa_pkg::t_state            r_state;
    bpfa_pkg::t_state            n_state;
    logic [WA_W-1:0]             r_clr;
    logic [bpfa_pkg::CFG_W-1:0]  r_page;
    logic [bpfa_pkg::CFG_W-1:0]  r_end;
    logic [bpfa_pkg::PAGE_W-1:0] r_res_page;
    logic                        r_res_oom;
    logic                        r_out_valid;
    logic [bpfa_pkg::PAGE_W-1:0] r_out_page;
    logic                        r_out_status;

    // bitmap memory
    logic [bpfa_pkg::WORD_W-1:0] r_bitmap [NUM_WORDS];
    logic [bpfa_pkg::WORD_W-1:0] r_rd_data;
    logic                        mem_we;
    logic                        mem_re;
    logic [WA_W-1:0]             mem_addr;
    logic [bpfa_pkg::WORD_W-1:0] mem_wdata;
    logic [bpfa_pkg::WORD_W-1:0] bit_mask;

    logic                        cfg_wr;
    logic                        in_acc;
    logic                        load_out;
    logic                        page_lt_end;
    logic                        free_in_range;
    logic [bpfa_pkg::CFG_W-1:0]  sel_first;
    logic [bpfa_pkg::CFG_W-1:0]  sel_end;
    logic [bpfa_pkg::CFG_W-1:0]  clip_end;
    logic [bpfa_pkg::CFG_W-1:0]  in_page;
    bpfa_pkg::t_scan_res         scan;

    bpfa_word_scan u_scan (
        .i_word (r_rd_data),
        .i_page (r_page),
        .i_end  (r_end),
        .o_res  (scan)
    );

    // ------------------------------------------------------------------------
    // APB
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            bpfa_pkg::REG_KERNEL_FIRST: prdata = bpfa_pkg::PDATA_W'(r_kernel_first);
            bpfa_pkg::REG_KERNEL_END:   prdata = bpfa_pkg::PDATA_W'(r_kernel_end);
            bpfa_pkg::REG_USER_FIRST:   prdata = bpfa_pkg::PDATA_W'(r_user_first);
            bpfa_pkg::REG_USER_END:     prdata = bpfa_pkg::PDATA_W'(r_user_end);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_first <= bpfa_pkg::KERNEL_FIRST_RST;
            r_kernel_end   <= bpfa_pkg::KERNEL_END_RST;
            r_user_first   <= bpfa_pkg::USER_FIRST_RST;
            r_user_end     <= bpfa_pkg::USER_END_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                bpfa_pkg::REG_KERNEL_FIRST: r_kernel_first <= pwdata[bpfa_pkg::CFG_W-1:0];
                bpfa_pkg::REG_KERNEL_END:   r_kernel_end   <= pwdata[bpfa_pkg::CFG_W-1:0];
                bpfa_pkg::REG_USER_FIRST:   r_user_first   <= pwdata[bpfa_pkg::CFG_W-1:0];
                bpfa_pkg::REG_USER_END:     r_user_end     <= pwdata[bpfa_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------------
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_page       = bpfa_pkg::CFG_W'(s_axis_tdata[bpfa_pkg::PAGE_W-1:0]);
    assign free_in_range = in_page < PAGES_LIM;
    assign sel_first     = s_axis_tuser[1] ? r_user_first : r_kernel_first;
    assign sel_end       = s_axis_tuser[1] ? r_user_end   : r_kernel_end;
    // stop the search at the end of the bitmap
    assign clip_end      = (sel_end > PAGES_LIM) ? PAGES_LIM : sel_end;
    assign page_lt_end   = r_page < r_end;

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            bpfa_pkg::ST_CLEAR: begin
                if (r_clr == LAST_WORD) begin
                    n_state = bpfa_pkg::ST_IDLE;
                end
            end
            bpfa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser[0] == bpfa_pkg::CMD_ALLOC) begin
                        n_state = bpfa_pkg::ST_SCAN_RD;
                    end else if (free_in_range) begin
                        n_state = bpfa_pkg::ST_FREE_RD;
                    end else begin
                        n_state = bpfa_pkg::ST_RESP;
                    end
                end
            end
            bpfa_pkg::ST_FREE_RD:  n_state = bpfa_pkg::ST_FREE_WR;
            bpfa_pkg::ST_FREE_WR:  n_state = bpfa_pkg::ST_RESP;
            bpfa_pkg::ST_SCAN_RD: begin
                n_state = page_lt_end ? bpfa_pkg::ST_SCAN_CHK : bpfa_pkg::ST_RESP;
            end
            bpfa_pkg::ST_SCAN_CHK: begin
                if (scan.hit) begin
                    n_state = bpfa_pkg::ST_ALLOC_WR;
                end else if (scan.past_end) begin
                    n_state = bpfa_pkg::ST_RESP;
                end else begin
                    n_state = bpfa_pkg::ST_SCAN_RD;
                end
            end
            bpfa_pkg::ST_ALLOC_WR: n_state = bpfa_pkg::ST_RESP;
            bpfa_pkg::ST_RESP: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = bpfa_pkg::ST_IDLE;
                end
            end
            default: n_state = bpfa_pkg::ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------------
    // outputs of the sequencer
    // ------------------------------------------------------------------------
    assign bit_mask = bpfa_pkg::WORD_W'(1) << r_page[bpfa_pkg::BIT_W-1:0];

    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = r_page[bpfa_pkg::BIT_W +: WA_W];
        mem_wdata     = r_rd_data;
        load_out      = 1'b0;
        case (r_state)
            bpfa_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '1;
            end
            bpfa_pkg::ST_IDLE:     s_axis_tready = 1'b1;
            bpfa_pkg::ST_FREE_RD:  mem_re = 1'b1;
            bpfa_pkg::ST_FREE_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd_data & ~bit_mask;
            end
            bpfa_pkg::ST_SCAN_RD:  mem_re = page_lt_end;
            bpfa_pkg::ST_SCAN_CHK: begin
            end
            bpfa_pkg::ST_ALLOC_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd_data | bit_mask;
            end
            bpfa_pkg::ST_RESP:     load_out = !r_out_valid || m_axis_tready;
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // bitmap RAM
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_bitmap[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_bitmap[mem_addr];
        end
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpfa_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bpfa_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            bpfa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_res_page <= '0;
                    r_res_oom  <= 1'b0;
                    r_end      <= clip_end;
                    r_page     <= (s_axis_tuser[0] == bpfa_pkg::CMD_ALLOC) ? sel_first : in_page;
                end
            end
            bpfa_pkg::ST_SCAN_RD: begin
                if (!page_lt_end) begin
                    r_res_oom <= 1'b1;
                end
            end
            bpfa_pkg::ST_SCAN_CHK: begin
                if (scan.hit) begin
                    r_page     <= scan.page;
                    r_res_page <= scan.page[bpfa_pkg::PAGE_W-1:0];
                end else if (scan.past_end) begin
                    r_res_oom <= 1'b1;
                end else begin
                    // advance to the next word
                    r_page <= scan.next_page;
                end
            end
            default: begin
            end
        endcase
        if (load_out) begin
            r_out_page   <= r_res_page;
            r_out_status <= r_res_oom;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 24'(r_out_page);
    assign m_axis_tuser  = r_out_status;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_hit_writes_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpfa_pkg::ST_SCAN_CHK && scan.hit)
        |=> (r_state == bpfa_pkg::ST_ALLOC_WR && mem_we))
        else $error("found page not marked used");

    a_alloc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpfa_pkg::ST_ALLOC_WR) |-> (r_page < r_end && r_res_oom == 1'b0))
        else $error("allocated page outside search range");

    a_read_in_bitmap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |-> (int'(mem_addr) < int'(NUM_WORDS)))
        else $error("bitmap read beyond last word");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != bpfa_pkg::ST_IDLE && !s_axis_tready))
        else $error("request accepted while another in flight");

endmodule
